// ===== rtl/core/reset_retry_backoff_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Reset retry backoff scheduler: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RESET_RETRY_BACKOFF_SCHEDULER_MACROS_SVH
`define RESET_RETRY_BACKOFF_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrbs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrbs assertion failed");

`endif

// ===== rtl/core/rrbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reset retry backoff scheduler package
// Event codes, reset kinds, register indexes and the scheduler state type.
// ----------------------------------------------------------------------------
package rrbs_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned FUNC_W = 3;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// Event codes
	localparam logic [FUNC_W-1:0] FUNC_REQUEST  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FAILED   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_PG_FELL  = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_PG_ROSE  = 3'd5;

	// Reset kinds
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PERST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY     = 1'b1;

	localparam logic [TIME_W-1:0] INITIAL_DELAY_RST = 32'd1000;
	localparam logic [TIME_W-1:0] MAX_DELAY_RST     = 32'd60000;
	localparam logic [TIME_W-1:0] TRIP_WINDOW_MS    = 32'd1000;

	typedef struct packed {
		logic [KIND_W-1:0] pending;
		logic [TIME_W-1:0] retry_at;
		logic [TIME_W-1:0] retry_delay;
		logic [TIME_W-1:0] last_trip;
		logic              trip_seen;
		logic              severe;
		logic              recovery;
	} rrbs_state_t;

	localparam rrbs_state_t STATE_RST = '{
		pending:     KIND_NONE,
		retry_at:    '0,
		retry_delay: '0,
		last_trip:   '0,
		trip_seen:   1'b0,
		severe:      1'b0,
		recovery:    1'b0
	};

endpackage

// ===== rtl/core/rrbs_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reset retry backoff scheduler: state update
// Next-state logic for one event word, plus the due and hold results.
// ----------------------------------------------------------------------------
module rrbs_update import rrbs_pkg::*; (
	input  logic [TIME_W-1:0] initial_delay_ms,
	input  logic [TIME_W-1:0] max_delay_ms,
	input  logic [FUNC_W-1:0] func,
	input  logic [KIND_W-1:0] reset_kind,
	input  logic [TIME_W-1:0] now_ms,
	input  rrbs_state_t       state_cur,
	output rrbs_state_t       state_nxt,
	output logic              due,
	output logic              hold
);

	logic [KIND_W-1:0] req_kind;
	logic [KIND_W-1:0] clip_kind;
	logic              do_queue;
	logic [TIME_W-1:0] fail_delay;
	logic [TIME_W:0]   doubled;
	logic [TIME_W-1:0] since_trip;
	logic [TIME_W-1:0] to_retry;

	always_comb begin
		req_kind = KIND_NONE;
		do_queue = 1'b0;
		case (func)
			FUNC_REQUEST: begin
				req_kind = reset_kind;
				do_queue = (reset_kind != KIND_NONE);
			end
			FUNC_PG_FELL, FUNC_PG_ROSE: begin
				req_kind = KIND_FULL;
				do_queue = 1'b1;
			end
			default: begin
				req_kind = KIND_NONE;
				do_queue = 1'b0;
			end
		endcase
	end

	// The unused kind code three counts as a full reset.
	assign clip_kind = (req_kind > KIND_FULL) ? KIND_FULL : req_kind;

	assign fail_delay = (state_cur.retry_delay == '0) ? initial_delay_ms
		: state_cur.retry_delay;
	assign doubled    = {fail_delay, 1'b0};
	assign since_trip = now_ms - state_cur.last_trip;

	always_comb begin
		state_nxt = state_cur;
		hold      = 1'b0;
		if (do_queue) begin
			if (clip_kind > state_cur.pending) begin
				state_nxt.pending = clip_kind;
			end
			state_nxt.retry_at = now_ms;
			if (state_cur.retry_delay == '0) begin
				state_nxt.retry_delay = initial_delay_ms;
			end
		end
		case (func)
			FUNC_FAILED: begin
				state_nxt.retry_at = now_ms + fail_delay;
				if (doubled > {1'b0, max_delay_ms}) begin
					state_nxt.retry_delay = max_delay_ms;
				end else begin
					state_nxt.retry_delay = doubled[TIME_W-1:0];
				end
			end
			FUNC_COMPLETE: begin
				state_nxt.pending     = KIND_NONE;
				state_nxt.retry_at    = '0;
				state_nxt.retry_delay = initial_delay_ms;
			end
			FUNC_PG_FELL: begin
				hold               = 1'b1;
				state_nxt.recovery = 1'b1;
				// A second trip inside the window marks a severe fault.
				if (state_cur.trip_seen && (since_trip < TRIP_WINDOW_MS)) begin
					state_nxt.severe = 1'b1;
				end
				state_nxt.last_trip = now_ms;
				state_nxt.trip_seen = 1'b1;
			end
			FUNC_PG_ROSE: begin
				state_nxt.recovery = 1'b1;
			end
			default: begin
				state_nxt.recovery = state_cur.recovery;
			end
		endcase
	end

	// Wrap-safe compare: the retry time has arrived when the signed gap is not negative.
	assign to_retry = now_ms - state_nxt.retry_at;
	assign due      = (state_nxt.pending != KIND_NONE) && !to_retry[TIME_W-1];

endmodule

// ===== rtl/core/reset_retry_backoff_scheduler.sv =====
`timescale 1ns / 1ps
// An accepted word is held in the input register, then passes the state update into the
// result registers. Throughput: one word per cycle unless the output stalls, set by the
// single state update between input and result registers; an empty input register takes
// a word while a finished result waits. Reset: arst_n clears the scheduler state and the
// valid flags and loads the delay registers with 1000 ms and 60000 ms.
// ----------------------------------------------------------------------------
// Reset retry backoff scheduler
// Event-driven reset recovery scheduling with capped exponential backoff.
// ----------------------------------------------------------------------------
`include "reset_retry_backoff_scheduler_macros.svh"

module reset_retry_backoff_scheduler import rrbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FUNC_W-1:0]    func,
	input  logic [KIND_W-1:0]    reset_kind,
	input  logic [TIME_W-1:0]    now_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 due,
	output logic [KIND_W-1:0]    pending_kind,
	output logic [TIME_W-1:0]    next_retry_ms,
	output logic                 hold_in_reset,
	output logic                 recovery_flag,
	output logic                 severe_flag
);

	logic [TIME_W-1:0] initial_delay_q;
	logic [TIME_W-1:0] max_delay_q;

	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [TIME_W-1:0] now_s1;

	rrbs_state_t state_q;
	rrbs_state_t state_nxt;
	logic        due_nxt;
	logic        hold_nxt;

	logic              out_valid_q;
	logic              due_q;
	logic [KIND_W-1:0] pending_q;
	logic [TIME_W-1:0] retry_q;
	logic              hold_q;
	logic              recovery_q;
	logic              severe_q;

	logic advance;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q <= INITIAL_DELAY_RST;
			max_delay_q     <= MAX_DELAY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INITIAL_DELAY: initial_delay_q <= cfg_data;
				REG_MAX_DELAY:     max_delay_q     <= cfg_data;
				default:           initial_delay_q <= initial_delay_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1 <= func;
			kind_s1 <= reset_kind;
			now_s1  <= now_ms;
		end
	end

	rrbs_update u_update (
		.initial_delay_ms (initial_delay_q),
		.max_delay_ms     (max_delay_q),
		.func             (func_s1),
		.reset_kind       (kind_s1),
		.now_ms           (now_s1),
		.state_cur        (state_q),
		.state_nxt        (state_nxt),
		.due              (due_nxt),
		.hold             (hold_nxt)
	);

	// State moves on together with the result register, so the next word sees it at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			due_q      <= due_nxt;
			pending_q  <= state_nxt.pending;
			retry_q    <= state_nxt.retry_at;
			hold_q     <= hold_nxt;
			recovery_q <= state_nxt.recovery;
			severe_q   <= state_nxt.severe;
		end
	end

	assign out_valid     = out_valid_q;
	assign due           = due_q;
	assign pending_kind  = pending_q;
	assign next_retry_ms = retry_q;
	assign hold_in_reset = hold_q;
	assign recovery_flag = recovery_q;
	assign severe_flag   = severe_q;

	`RRBS_ASSERT_NOW(a_due_needs_pending, out_valid_q && due_q, pending_q != KIND_NONE)
	`RRBS_ASSERT_NOW(a_hold_sets_recovery, out_valid_q && hold_q,
		recovery_q && (pending_q == KIND_FULL))
	`RRBS_ASSERT_NEXT(a_severe_sticky, state_q.severe, state_q.severe)
	`RRBS_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready)
	`RRBS_ASSERT_NOW(a_pending_legal, 1'b1, state_q.pending <= KIND_FULL)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reset retry backoff scheduler testbench
// Drives event words through the valid/ready input with bursty timing, predicts
// every report from a local copy of the scheduler state and the delay registers,
// and checks each report field by field while the output side stalls in patterns.
// ----------------------------------------------------------------------------
module tb;
	import rrbs_pkg::*;

	// Event codes outside the defined set, and the out-of-range reset kind.
	localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
	localparam logic [KIND_W-1:0] KIND_OVER    = 2'd3;
	localparam int                QUIET_LIMIT  = 2000;

	typedef struct packed {
		logic              due;
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] retry_at;
		logic              hold;
		logic              recovery;
		logic              severe;
	} sched_report_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = REG_INITIAL_DELAY;
	logic [TIME_W-1:0]    cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [FUNC_W-1:0]    func       = FUNC_QUERY;
	logic [KIND_W-1:0]    reset_kind = KIND_NONE;
	logic [TIME_W-1:0]    now_ms     = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic                 due;
	logic [KIND_W-1:0]    pending_kind;
	logic [TIME_W-1:0]    next_retry_ms;
	logic                 hold_in_reset;
	logic                 recovery_flag;
	logic                 severe_flag;

	// Local copy of the scheduler state and delay registers.
	logic [KIND_W-1:0] sched_pending   = KIND_NONE;
	logic [TIME_W-1:0] sched_retry_at  = '0;
	logic [TIME_W-1:0] sched_delay     = '0;
	logic [TIME_W-1:0] sched_last_trip = '0;
	logic              sched_trip_seen = 1'b0;
	logic              sched_severe    = 1'b0;
	logic              sched_recovery  = 1'b0;
	logic [TIME_W-1:0] reg_initial     = INITIAL_DELAY_RST;
	logic [TIME_W-1:0] reg_max         = MAX_DELAY_RST;

	sched_report_t expected_reports[$];
	int mismatches   = 0;
	int quiet_cycles = 0;
	int burst_left   = 0;
	int ready_mode   = 0;
	int ready_left   = 0;
	int ready_tick   = 0;

	reset_retry_backoff_scheduler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.reset_kind    (reset_kind),
		.now_ms        (now_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.due           (due),
		.pending_kind  (pending_kind),
		.next_retry_ms (next_retry_ms),
		.hold_in_reset (hold_in_reset),
		.recovery_flag (recovery_flag),
		.severe_flag   (severe_flag)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void queue_recovery(input logic [KIND_W-1:0] k,
			input logic [TIME_W-1:0] t);
		logic [KIND_W-1:0] kind_eff;
		if (k == KIND_NONE)
			return;
		kind_eff = (k > KIND_FULL) ? KIND_FULL : k;
		if (kind_eff > sched_pending)
			sched_pending = kind_eff;
		sched_retry_at = t;
		if (sched_delay == '0)
			sched_delay = reg_initial;
	endfunction

	function automatic sched_report_t schedule_event(input logic [FUNC_W-1:0] f,
			input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t);
		sched_report_t     r;
		logic [TIME_W-1:0] delay;
		logic [TIME_W:0]   doubled;
		logic [TIME_W-1:0] since_trip;
		logic [TIME_W-1:0] lag;
		r = '0;
		case (f)
			FUNC_REQUEST: queue_recovery(k, t);
			FUNC_FAILED: begin
				delay = (sched_delay == '0) ? reg_initial : sched_delay;
				sched_retry_at = t + delay;
				// The doubling is one bit wider so that it saturates at the cap.
				doubled = {delay, 1'b0};
				sched_delay = (doubled > {1'b0, reg_max}) ? reg_max : doubled[TIME_W-1:0];
			end
			FUNC_COMPLETE: begin
				sched_pending = KIND_NONE;
				sched_retry_at = '0;
				sched_delay = reg_initial;
			end
			FUNC_PG_FELL: begin
				r.hold = 1'b1;
				sched_recovery = 1'b1;
				queue_recovery(KIND_FULL, t);
				since_trip = t - sched_last_trip;
				if (sched_trip_seen && since_trip < TRIP_WINDOW_MS)
					sched_severe = 1'b1;
				sched_last_trip = t;
				sched_trip_seen = 1'b1;
			end
			FUNC_PG_ROSE: begin
				sched_recovery = 1'b1;
				queue_recovery(KIND_FULL, t);
			end
			default: ;
		endcase
		lag = t - sched_retry_at;
		r.due = (sched_pending != KIND_NONE) && !lag[TIME_W-1];
		r.kind = sched_pending;
		r.retry_at = sched_retry_at;
		r.recovery = sched_recovery;
		r.severe = sched_severe;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Sends one event word; the sender runs in bursts with idle gaps between them.
	task automatic send_event(input logic [FUNC_W-1:0] f, input logic [KIND_W-1:0] k,
			input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		reset_kind <= k;
		now_ms <= t;
		do @(posedge clk); while (!in_ready);
		expected_reports.push_back(schedule_event(f, k, t));
	endtask

	task automatic settle_pipeline();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [TIME_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_INITIAL_DELAY)
			reg_initial = value;
		else
			reg_max = value;
		@(posedge clk);
	endtask

	task automatic test_event_codes();
		send_event(FUNC_QUERY, KIND_NONE, 32'h0000_0000);
		send_event(FUNC_REQUEST, KIND_NONE, 32'hFFFF_FFFF);
		// A failure with nothing pending still starts the backoff.
		send_event(FUNC_FAILED, KIND_PERST, 32'd100);
		send_event(FUNC_REQUEST, KIND_PERST, 32'd200);
		send_event(FUNC_REQUEST, KIND_OVER, 32'd300);
		send_event(FUNC_FAILED, KIND_NONE, 32'd500);
		send_event(FUNC_QUERY, KIND_FULL, 32'd2500);
		send_event(FUNC_SPARE_6, KIND_OVER, 32'h8000_0000);
		send_event(FUNC_SPARE_7, KIND_PERST, 32'h7FFF_FFFF);
		send_event(FUNC_COMPLETE, KIND_FULL, 32'hFFFF_FFFF);
		send_event(FUNC_FAILED, KIND_OVER, 32'hFFFF_FF00);
	endtask

	task automatic test_power_trips();
		send_event(FUNC_PG_ROSE, KIND_NONE, 32'd10);
		// The first fall has no earlier trip to compare with.
		send_event(FUNC_PG_FELL, KIND_PERST, 32'd5);
		send_event(FUNC_PG_FELL, KIND_NONE, 32'd1005);
		send_event(FUNC_COMPLETE, KIND_NONE, 32'd1100);
		send_event(FUNC_PG_FELL, KIND_NONE, 32'hFFFF_FE00);
		// Second fall 999 ms later, across the wrap of the counter.
		send_event(FUNC_PG_FELL, KIND_NONE, 32'h0000_01E7);
	endtask

	task automatic test_backoff_limits();
		settle_pipeline();
		write_register(REG_INITIAL_DELAY, 32'd1);
		write_register(REG_MAX_DELAY, 32'd1);
		send_event(FUNC_COMPLETE, KIND_NONE, 32'd0);
		send_event(FUNC_REQUEST, KIND_FULL, 32'h7FFF_FFFF);
		send_event(FUNC_FAILED, KIND_NONE, 32'h7FFF_FFFF);
		send_event(FUNC_QUERY, KIND_NONE, 32'h8000_0000);
		settle_pipeline();
		write_register(REG_INITIAL_DELAY, 32'hFFFF_FFFF);
		write_register(REG_MAX_DELAY, 32'hFFFF_FFFF);
		send_event(FUNC_COMPLETE, KIND_NONE, 32'd0);
		send_event(FUNC_REQUEST, KIND_PERST, 32'd5);
		send_event(FUNC_FAILED, KIND_NONE, 32'd5);
		settle_pipeline();
		// Initial delay above the cap: the first doubling drops to the cap.
		write_register(REG_INITIAL_DELAY, 32'd5000);
		write_register(REG_MAX_DELAY, 32'd100);
		send_event(FUNC_COMPLETE, KIND_NONE, 32'd0);
		send_event(FUNC_FAILED, KIND_NONE, 32'd0);
		send_event(FUNC_FAILED, KIND_NONE, 32'd0);
	endtask

	task automatic test_random_traffic();
		logic [TIME_W-1:0] clock_ms;
		logic [FUNC_W-1:0] f;
		int                phase;
		int                n;
		int                pick;
		for (phase = 0; phase < 4; phase++) begin
			settle_pipeline();
			case (phase)
				0: begin
					write_register(REG_INITIAL_DELAY, $urandom_range(200, 2000));
					write_register(REG_MAX_DELAY, $urandom_range(1000, 60000));
				end
				1: begin
					write_register(REG_INITIAL_DELAY, $urandom_range(1, 50));
					write_register(REG_MAX_DELAY, $urandom_range(1, 3000));
				end
				2: begin
					write_register(REG_INITIAL_DELAY, $urandom_range(1, 32'hFFFF_FFFF));
					write_register(REG_MAX_DELAY, $urandom_range(1, 32'hFFFF_FFFF));
				end
				default: begin
					write_register(REG_INITIAL_DELAY, $urandom_range(1, 500));
					write_register(REG_MAX_DELAY, 32'hFFFF_FFFF);
				end
			endcase
			clock_ms = (phase == 1) ? 32'hFFFF_F000 + $urandom_range(0, 2047) : $urandom;
			for (n = 0; n < 240; n++) begin
				// Hold off mid-phase until every outstanding report has come back.
				if (phase == 2 && n == 120)
					settle_pipeline();
				pick = $urandom_range(0, 99);
				if (pick < 65)
					clock_ms += $urandom_range(0, 1200);
				else if (pick < 80)
					clock_ms += $urandom_range(0, 70000);
				else if (pick < 88)
					clock_ms -= $urandom_range(1, 500);
				else if (pick >= 93)
					clock_ms = $urandom;
				pick = $urandom_range(0, 99);
				if (pick < 18)
					f = FUNC_REQUEST;
				else if (pick < 33)
					f = FUNC_QUERY;
				else if (pick < 53)
					f = FUNC_FAILED;
				else if (pick < 63)
					f = FUNC_COMPLETE;
				else if (pick < 76)
					f = FUNC_PG_FELL;
				else if (pick < 88)
					f = FUNC_PG_ROSE;
				else if (pick < 94)
					f = FUNC_QUERY;
				else
					f = pick[0] ? FUNC_SPARE_7 : FUNC_SPARE_6;
				send_event(f, KIND_W'($urandom_range(0, 3)), clock_ms);
			end
		end
	endtask

	always @(posedge clk) begin : result_checker
		sched_report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				$display("%0t ns: report word with none expected, expected nothing, got %0h",
					$time, next_retry_ms);
				mismatches++;
			end else begin
				want = expected_reports.pop_front();
				check_field("due", TIME_W'(want.due), TIME_W'(due));
				check_field("pending_kind", TIME_W'(want.kind), TIME_W'(pending_kind));
				check_field("next_retry_ms", want.retry_at, next_retry_ms);
				check_field("hold_in_reset", TIME_W'(want.hold), TIME_W'(hold_in_reset));
				check_field("recovery_flag", TIME_W'(want.recovery), TIME_W'(recovery_flag));
				check_field("severe_flag", TIME_W'(want.severe), TIME_W'(severe_flag));
			end
		end
	end

	// The receiver switches between free flow, coin-flip stalls, a one-in-four
	// pattern and rare random stalls.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(32, 200);
		end else begin
			ready_left--;
		end
		ready_tick++;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (ready_tick % 4 == 0);
			default: out_ready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[reset_retry_backoff_scheduler] ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_event_codes();
		test_power_trips();
		test_backoff_limits();
		test_random_traffic();
		settle_pipeline();
		if (mismatches == 0)
			$display("[reset_retry_backoff_scheduler] OK");
		else
			$display("[reset_retry_backoff_scheduler] ERROR");
		$finish;
	end

endmodule

// ===== reset_retry_backoff_scheduler.f =====
+incdir+rtl/core
rtl/core/rrbs_pkg.sv
rtl/core/rrbs_update.sv
rtl/core/reset_retry_backoff_scheduler.sv
test/tb.sv
